// ----- rtl/des_key_schedule_unit_assert.svh -----
// Assertion macros shared by the key schedule RTL.
`ifndef DES_KEY_SCHEDULE_UNIT_ASSERT_SVH
`define DES_KEY_SCHEDULE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key schedule assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key schedule assertion failed");

`endif

// ----- rtl/desks_pkg.sv -----
package desks_pkg;

  localparam int KeyW    = 64;
  localparam int HalfW   = 28;
  localparam int CdW     = 2 * HalfW;
  localparam int SubkeyW = 48;
  localparam int RoundW  = 4;
  localparam int OutW    = 56;

  localparam logic [RoundW-1:0] LastRound = 4'd15;

  typedef logic [KeyW-1:0]    key_t;
  typedef logic [CdW-1:0]     cd_t;
  typedef logic [SubkeyW-1:0] subkey_t;
  typedef logic [RoundW-1:0]  round_t;
  typedef logic [OutW-1:0]    out_data_t;

  // The first permuted choice (PC1), entries are DES bit numbers 1..64.
  localparam logic [7:0] Pc1Tab [CdW] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
    8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
    8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
    8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
    8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
    8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
    8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
  };

  // The second permuted choice (PC2), entries are bit numbers 1..56 of C and D.
  localparam logic [7:0] Pc2Tab [SubkeyW] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
    8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
    8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
    8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
    8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
  };

  // PC1: the first table entry lands in the top bit of C.
  function automatic cd_t pc1(input key_t key);
    cd_t res;
    for (int i = 0; i < CdW; i++) begin
      res[CdW-1-i] = key[KeyW - int'(Pc1Tab[i])];
    end
    return res;
  endfunction

  // PC2: the first table entry lands in the top bit of the subkey.
  function automatic subkey_t pc2(input cd_t cd);
    subkey_t res;
    for (int i = 0; i < SubkeyW; i++) begin
      res[SubkeyW-1-i] = cd[CdW - int'(Pc2Tab[i])];
    end
    return res;
  endfunction

  // The first two rounds, the ninth and the last shift by one place, all others by two.
  function automatic logic shift_two(input round_t round);
    logic two;
    case (round) inside
      4'd0, 4'd1, 4'd8, LastRound: two = 1'b0;
      default: two = 1'b1;
    endcase
    return two;
  endfunction

  // Rotate C and D left each within its own 28 bits.
  function automatic cd_t rotate_cd(input cd_t cd, input logic two);
    logic [HalfW-1:0] c;
    logic [HalfW-1:0] d;
    c = cd[CdW-1:HalfW];
    d = cd[HalfW-1:0];
    if (two) begin
      c = {c[HalfW-3:0], c[HalfW-1:HalfW-2]};
      d = {d[HalfW-3:0], d[HalfW-1:HalfW-2]};
    end else begin
      c = {c[HalfW-2:0], c[HalfW-1]};
      d = {d[HalfW-2:0], d[HalfW-1]};
    end
    return {c, d};
  endfunction

endpackage

// ----- rtl/des_key_schedule_unit.sv -----
// DES key schedule: one 64-bit key in, sixteen 48-bit round keys out.
// A key passes through the key stage (PC1), the round stage and the output stage (PC2) in order.
// Throughput: one subkey per cycle while out_tready is high and a key is queued; the key stage
// can take the next key while the round stage steps C and D through the previous key's rounds.
// Reset (rst_n low, synchronous) empties all stages; payload registers are not cleared.
`include "des_key_schedule_unit_assert.svh"

module des_key_schedule_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  desks_pkg::key_t        in_tdata,   // [63:0] key
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output desks_pkg::out_data_t   out_tdata,  // [3:0] round_index, [51:4] subkey, [55:52] zero
  output logic                   out_tlast   // last: sixteenth subkey of a key
);
  import desks_pkg::*;

  // Key stage: PC1 of the accepted key.
  logic    key_valid_r, key_valid_nxt;
  cd_t     key_cd_r;
  // Round stage: C and D already rotated for round gen_round_r.
  logic    gen_valid_r, gen_valid_nxt;
  cd_t     gen_cd_r, gen_cd_nxt;
  round_t  gen_round_r, gen_round_nxt;
  // Output stage: PC2 result.
  logic    out_valid_r, out_valid_nxt;
  subkey_t out_subkey_r;
  round_t  out_round_r;
  logic    out_last_r;

  logic out_free;
  logic gen_move;
  logic gen_open;
  logic gen_take;
  logic in_take;

  assign out_free = !out_valid_r || out_tready;
  assign gen_move = gen_valid_r && out_free;
  assign gen_open = !gen_valid_r || (gen_move && gen_round_r == LastRound);
  assign gen_take = gen_open && key_valid_r;
  assign in_tready = !key_valid_r || gen_take;
  assign in_take = in_tvalid && in_tready;

  // Key stage control.
  always_comb begin
    key_valid_nxt = key_valid_r;
    if (in_take) begin
      key_valid_nxt = 1'b1;
    end else if (gen_take) begin
      key_valid_nxt = 1'b0;
    end
  end

  // Round stage: load a key at round 0, go empty if none waits, else step to the next round.
  always_comb begin
    gen_valid_nxt = gen_valid_r;
    gen_cd_nxt    = gen_cd_r;
    gen_round_nxt = gen_round_r;
    if (gen_take) begin
      gen_valid_nxt = 1'b1;
      gen_cd_nxt    = rotate_cd(key_cd_r, shift_two('0));
      gen_round_nxt = '0;
    end else if (gen_open) begin
      gen_valid_nxt = 1'b0;
    end else if (gen_move) begin
      gen_round_nxt = gen_round_r + 4'd1;
      gen_cd_nxt    = rotate_cd(gen_cd_r, shift_two(gen_round_nxt));
    end
  end

  // Output stage control.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = gen_valid_r;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_valid_r <= 1'b0;
      gen_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key_valid_r <= key_valid_nxt;
      gen_valid_r <= gen_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_cd_r <= pc1(in_tdata);
    end
    gen_cd_r    <= gen_cd_nxt;
    gen_round_r <= gen_round_nxt;
    if (gen_move) begin
      out_subkey_r <= pc2(gen_cd_r);
      out_round_r  <= gen_round_r;
      out_last_r   <= (gen_round_r == LastRound);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutW - SubkeyW - RoundW){1'b0}}, out_subkey_r, out_round_r};
  assign out_tlast  = out_last_r;

  // The last flag marks exactly the sixteenth round.
  `DKS_ASSERT_IMPL(a_last_round, clk, rst_n, out_tvalid,
                   out_tlast == (out_tdata[3:0] == LastRound))
  // Rounds of one key follow each other without a gap.
  `DKS_ASSERT_NEXT(a_round_seq, clk, rst_n, out_tvalid && out_tready && !out_tlast,
                   out_tvalid && out_tdata[3:0] == 4'($past(out_tdata[3:0]) + 4'd1))
  // A key taken into the round stage starts at its first round.
  `DKS_ASSERT_NEXT(a_load_round, clk, rst_n, gen_take,
                   gen_valid_r && gen_round_r == '0)

endmodule
